[rtl/kmpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed max-priority queue package
// Transfer types, operation codes and status codes shared by the queue files.
// ----------------------------------------------------------------------------
package kmpq_pkg;

    // Operation codes carried in the input transfer.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // Status codes carried in the result transfer.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Identifier width: six ASCII characters.
    localparam int ID_BITS = 48;

    // One request.
    typedef struct packed {
        logic [1:0]         operation;
        logic [ID_BITS-1:0] aircraft_id;
        logic [15:0]        priority_value;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [2:0]         status;
        logic [ID_BITS-1:0] removed_id;
        logic [15:0]        removed_priority;
        logic [6:0]         entry_count;
    } out_item_t;

endpackage
`default_nettype wire

[rtl/keyed_max_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed max-priority queue
// A table of identifier/priority entries kept in insertion order with insert,
// remove-highest and update-by-identifier operations.
// ----------------------------------------------------------------------------
// Usage: a request is one transfer on the item channel (item_valid high and
// item_stall low at a clock edge). Each request yields exactly one transfer on
// the result channel carrying a status, the removed entry (zero unless a
// remove succeeded) and the entry count after the operation.
// One request is processed at a time; item_stall stays high while it runs.
// The entry table lives in a single RAM with one read and one write port, and
// one comparator walks it one entry per cycle. Insert and update scan up to
// N held entries. A remove scans all N entries for the first maximum, then
// moves the entries above it down one slot each cycle. On an empty table an
// insert goes straight to its write and an update or remove straight to its
// result, with no scan. The next request is accepted in the cycle after the
// result is loaded.
// Reset empties the table at once (no clearing pass); RAM contents are not
// reset and are only read below the held count.
// If the receiver stalls, the result waits in the output register and the
// block stops before loading the next result, so no result is dropped.
// ----------------------------------------------------------------------------
module keyed_max_priority_queue #(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire kmpq_pkg::in_item_t item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output kmpq_pkg::out_item_t     result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = PRIORITY_BITS;
    localparam int IW = kmpq_pkg::ID_BITS;
    localparam int EW = IW + PW;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_WRITE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [IW-1:0]       key_reg, key_next;
    logic [PW-1:0]       prio_reg, prio_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       issue_idx_reg, issue_idx_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [IW-1:0]       best_id_reg, best_id_next;
    logic [PW-1:0]       best_prio_reg, best_prio_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [2:0]          status_reg, status_next;
    logic [IW-1:0]       rem_id_reg, rem_id_next;
    logic [PW-1:0]       rem_prio_reg, rem_prio_next;
    logic                out_valid_reg, out_valid_next;
    kmpq_pkg::out_item_t out_data_reg, out_data_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [EW-1:0]       ram_wr_data;
    logic [EW-1:0]       ram_rd_data;

    logic [IW-1:0]       rd_id;
    logic [PW-1:0]       rd_prio;
    logic [AW-1:0]       last_idx;
    logic                cmp_last;
    logic                id_hit;
    logic                take_best;
    logic [AW-1:0]       cur_best_idx;
    logic [IW-1:0]       cur_best_id;
    logic [PW-1:0]       cur_best_prio;
    logic                table_full;
    logic                accept;
    logic [31:0]         in_prio_wide;
    logic [31:0]         rem_prio_wide;
    logic [31:0]         count_wide;

    // Entry table.
    kmpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (issue_idx_reg),
        .rd_data (ram_rd_data)
    );

    // Handshake and width adaptation.
    assign item_stall    = (state_reg != S_IDLE);
    assign accept        = item_valid && !item_stall;
    assign result_valid  = out_valid_reg;
    assign result        = out_data_reg;
    assign in_prio_wide  = 32'(item.priority_value);
    assign rem_prio_wide = 32'(rem_prio_reg);
    assign count_wide    = 32'(count_reg);

    // Shared comparator on the entry read back from the table.
    assign rd_id         = ram_rd_data[EW-1:PW];
    assign rd_prio       = ram_rd_data[PW-1:0];
    assign last_idx      = AW'(count_reg - CW'(1));
    assign cmp_last      = cmp_valid_reg && (cmp_idx_reg == last_idx);
    assign id_hit        = cmp_valid_reg && (rd_id == key_reg);
    assign take_best     = cmp_valid_reg && ((cmp_idx_reg == '0) || (rd_prio > best_prio_reg));
    assign cur_best_idx  = take_best ? cmp_idx_reg : best_idx_reg;
    assign cur_best_id   = take_best ? rd_id : best_id_reg;
    assign cur_best_prio = take_best ? rd_prio : best_prio_reg;
    assign table_full    = (count_reg == CW'(CAPACITY));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        prio_next      = prio_reg;
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        cmp_idx_next   = issue_idx_reg;
        cmp_valid_next = 1'b0;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        rem_id_next    = rem_id_reg;
        rem_prio_next  = rem_prio_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = slot_reg;
        ram_wr_data    = {key_reg, prio_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = item.operation;
                    key_next       = item.aircraft_id;
                    prio_next      = in_prio_wide[PW-1:0];
                    status_next    = kmpq_pkg::ST_OK;
                    rem_id_next    = '0;
                    rem_prio_next  = '0;
                    issue_idx_next = '0;
                    case (item.operation)
                        kmpq_pkg::OP_INSERT:
                        begin
                            if (count_reg == '0)
                            begin
                                slot_next  = '0;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        kmpq_pkg::OP_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = kmpq_pkg::ST_NOT_FOUND;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        kmpq_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = kmpq_pkg::ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle, holding at the last held slot.
                cmp_valid_next = 1'b1;
                if (issue_idx_reg != last_idx)
                begin
                    issue_idx_next = issue_idx_reg + AW'(1);
                end
                if (op_reg == kmpq_pkg::OP_REMOVE)
                begin
                    best_idx_next  = cur_best_idx;
                    best_id_next   = cur_best_id;
                    best_prio_next = cur_best_prio;
                    if (cmp_last)
                    begin
                        cmp_valid_next = 1'b0;
                        rem_id_next    = cur_best_id;
                        rem_prio_next  = cur_best_prio;
                        if (cur_best_idx == last_idx)
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            issue_idx_next = cur_best_idx + AW'(1);
                            state_next     = S_SHIFT;
                        end
                    end
                end
                else if (id_hit)
                begin
                    cmp_valid_next = 1'b0;
                    if (op_reg == kmpq_pkg::OP_INSERT)
                    begin
                        status_next = kmpq_pkg::ST_DUPLICATE;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        slot_next  = cmp_idx_reg;
                        state_next = S_WRITE;
                    end
                end
                else if (cmp_last)
                begin
                    cmp_valid_next = 1'b0;
                    if (op_reg == kmpq_pkg::OP_INSERT)
                    begin
                        if (table_full)
                        begin
                            status_next = kmpq_pkg::ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            slot_next  = count_reg[AW-1:0];
                            state_next = S_WRITE;
                        end
                    end
                    else
                    begin
                        status_next = kmpq_pkg::ST_NOT_FOUND;
                        state_next  = S_FINISH;
                    end
                end
            end

            S_SHIFT:
            begin
                // Move each entry above the removed one down by one slot.
                cmp_valid_next = 1'b1;
                if (issue_idx_reg != last_idx)
                begin
                    issue_idx_next = issue_idx_reg + AW'(1);
                end
                if (cmp_valid_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cmp_idx_reg - AW'(1);
                    ram_wr_data = ram_rd_data;
                end
                if (cmp_last)
                begin
                    cmp_valid_next = 1'b0;
                    count_next     = count_reg - CW'(1);
                    state_next     = S_FINISH;
                end
            end

            S_WRITE:
            begin
                // Store the new or updated entry.
                ram_wr_en = 1'b1;
                if (op_reg == kmpq_pkg::OP_INSERT)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.status           = status_reg;
                    out_data_next.removed_id       = rem_id_reg;
                    out_data_next.removed_priority = rem_prio_wide[15:0];
                    out_data_next.entry_count      = count_wide[6:0];
                    state_next                     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        prio_reg      <= prio_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        rem_id_reg    <= rem_id_next;
        rem_prio_reg  <= rem_prio_next;
        out_data_reg  <= out_data_next;
    end

endmodule
`default_nettype wire

[rtl/kmpq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kmpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
